// ===== design/sarp_pkg.sv =====
// sarp_pkg: shared types and constants for the servo angle ramp to pwm core
// holds command codes, register indexes, reset values and sequencer states
// no dependencies
`timescale 1ns / 1ps

package sarp_pkg;

    localparam int FUNC_W  = 2;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int MS_W    = 16;
    localparam int PULSE_W = 16;
    localparam int CUR_W   = 13;
    localparam int OFS_W   = 14;
    localparam int PPU_W   = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // shared multiplier: 33 x 33 signed, low bits kept
    localparam int MUL_IN_W  = 33;
    localparam int MUL_OUT_W = 62;

    // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam logic [MUL_IN_W-1:0] DIV_MAGIC = 33'd274877907;
    localparam int DIV_SHIFT = 38;
    localparam int STEP_W    = 23;
    localparam int NEXT_W    = 25;

    // pulse arithmetic
    localparam int PROD_FRAC = 16;
    localparam int PART_W    = 26;
    localparam int P_W       = 28;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2000;
    localparam logic [CUR_W-1:0]   MAX_ANGLE_RST = 13'd2880;
    localparam logic [PPU_W-1:0]   PPU_RST       = 24'd22756;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET    = 2'd0,
        FUNC_MOVE   = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PULSE  = 3'd0,
        CFG_MAX_PULSE  = 3'd1,
        CFG_MAX_ANGLE  = 3'd2,
        CFG_OFFSET     = 3'd3,
        CFG_INVERT     = 3'd4,
        CFG_PPU        = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_STEP_CMP,
        ST_PULSE_MUL,
        ST_PULSE_CLAMP,
        ST_RESULT
    } state_t;

endpackage

// ===== design/servo_angle_ramp_to_pwm_core.sv =====
// servo_angle_ramp_to_pwm_core: servo command unit with slew-limited moves
// and angle to pwm compare mapping on one shared multiplier; uses sarp_pkg
//
// steps: move, or tick with no ramp, go dispatch then result; set angle adds pulse mul
//   and pulse clamp; a ramping tick adds step mul, step div, step cmp, then pulse mul and
//   clamp unless at target; one request in flight, ready only when idle; the single
//   33x33 multiplier forms step product, divide-by-1000 reciprocal and pulse in turn
// reset: rst_n asynchronous, clears state and loads register defaults
`timescale 1ns / 1ps

module servo_angle_ramp_to_pwm_core
    import sarp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // angle[15:0] speed[31:16] elapsed_ms[47:32]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // pulse_width[15:0] current_angle[28:16]
                                             // arrived[29] moving[30] zero[31]
);

    // configuration
    logic [PULSE_W-1:0]      min_pulse_reg;
    logic [PULSE_W-1:0]      max_pulse_reg;
    logic [CUR_W-1:0]        max_angle_reg;
    logic signed [OFS_W-1:0] offset_reg;
    logic                    invert_reg;
    logic [PPU_W-1:0]        ppu_reg;

    // servo state
    logic [CUR_W-1:0]          angle_now_reg;
    logic signed [ANGLE_W-1:0] angle_target_reg;
    logic [SPEED_W-1:0]        ramp_speed_reg;
    logic                      ramp_active_reg;
    logic [PULSE_W-1:0]        pulse_reg;

    // request and work registers
    func_t                     func_reg;
    logic signed [ANGLE_W-1:0] angle_in_reg;
    logic [SPEED_W-1:0]        speed_in_reg;
    logic [MS_W-1:0]           ms_in_reg;
    logic signed [ANGLE_W-1:0] drive_reg;
    logic                      arrived_reg;
    logic signed [MUL_OUT_W-1:0] mul_reg;

    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    state_t state_reg, state_next;

    logic accept;
    logic out_free;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // shared multiplier operand select
    logic signed [MUL_IN_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_IN_W-1:0] mul_full;
    logic signed [ANGLE_W:0]      drive_ofs;

    assign drive_ofs = {drive_reg[ANGLE_W-1], drive_reg} + {{(ANGLE_W+1-OFS_W){offset_reg[OFS_W-1]}},
                       offset_reg};

    always_comb
    begin
        case (state_reg)
            ST_STEP_MUL:
            begin
                mul_a = {{(MUL_IN_W-MS_W){1'b0}}, ms_in_reg};
                mul_b = {{(MUL_IN_W-SPEED_W){1'b0}}, ramp_speed_reg};
            end
            ST_STEP_DIV:
            begin
                mul_a = {1'b0, mul_reg[MUL_IN_W-2:0]};
                mul_b = DIV_MAGIC;
            end
            default:
            begin
                mul_a = {{(MUL_IN_W-PPU_W){1'b0}}, ppu_reg};
                mul_b = {{(MUL_IN_W-ANGLE_W-1){drive_ofs[ANGLE_W]}}, drive_ofs};
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // tick step: next angle and overshoot test
    logic [STEP_W-1:0]        step;
    logic signed [NEXT_W-1:0] cur_w, tgt_w, step_w, next_w;
    logic                     cur_above, over, at_target;

    assign step      = mul_reg[DIV_SHIFT+STEP_W-1:DIV_SHIFT];
    assign cur_w     = {{(NEXT_W-CUR_W){1'b0}}, angle_now_reg};
    assign tgt_w     = {{(NEXT_W-ANGLE_W){angle_target_reg[ANGLE_W-1]}}, angle_target_reg};
    assign step_w    = {{(NEXT_W-STEP_W){1'b0}}, step};
    assign cur_above = cur_w > tgt_w;
    assign next_w    = cur_above ? cur_w - step_w : cur_w + step_w;
    assign over      = cur_above ? (next_w < tgt_w) : (next_w > tgt_w);
    assign at_target = cur_w == tgt_w;

    // pulse mapping and clamps
    logic signed [MUL_OUT_W-1:0] prod_adj;
    logic signed [MUL_OUT_W-1:0] prod_shr;
    logic signed [PART_W-1:0]    part;
    logic signed [P_W-1:0]       min_w, max_w, p_raw;
    logic [PULSE_W-1:0]          pulse_new;
    logic signed [ANGLE_W:0]     max_angle_s;
    logic [CUR_W-1:0]            angle_new;

    // truncate toward zero: bias negative products before the shift
    assign prod_adj = mul_reg[MUL_OUT_W-1] ? mul_reg + MUL_OUT_W'((1 << PROD_FRAC) - 1) : mul_reg;
    assign prod_shr = prod_adj >>> PROD_FRAC;
    assign part     = prod_shr[PART_W-1:0];
    assign min_w    = {{(P_W-PULSE_W){1'b0}}, min_pulse_reg};
    assign max_w    = {{(P_W-PULSE_W){1'b0}}, max_pulse_reg};
    assign p_raw    = invert_reg ? max_w - {{(P_W-PART_W){part[PART_W-1]}}, part}
                                 : min_w + {{(P_W-PART_W){part[PART_W-1]}}, part};

    always_comb
    begin
        if (p_raw > max_w)
            pulse_new = max_pulse_reg;
        else if (p_raw < min_w)
            pulse_new = min_pulse_reg;
        else
            pulse_new = p_raw[PULSE_W-1:0];
    end

    assign max_angle_s = {{(ANGLE_W+1-CUR_W){1'b0}}, max_angle_reg};

    always_comb
    begin
        if ($signed({drive_reg[ANGLE_W-1], drive_reg}) < max_angle_s)
            angle_new = (drive_reg > 0) ? drive_reg[CUR_W-1:0] : '0;
        else
            angle_new = max_angle_reg;
    end

    // move target clamp
    logic signed [ANGLE_W:0]   move_sum;
    logic signed [ANGLE_W-1:0] target_new;

    assign move_sum = {angle_in_reg[ANGLE_W-1], angle_in_reg}
                    + {{(ANGLE_W+1-OFS_W){offset_reg[OFS_W-1]}}, offset_reg};

    always_comb
    begin
        if (move_sum > max_angle_s)
            target_new = {{(ANGLE_W-CUR_W){1'b0}}, max_angle_reg};
        else if (move_sum < 0)
            target_new = '0;
        else
            target_new = angle_in_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                case (func_reg)
                    FUNC_SET:  state_next = ST_PULSE_MUL;
                    FUNC_TICK: state_next = ramp_active_reg ? ST_STEP_MUL : ST_RESULT;
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_STEP_MUL:    state_next = ST_STEP_DIV;
            ST_STEP_DIV:    state_next = ST_STEP_CMP;
            ST_STEP_CMP:    state_next = at_target ? ST_RESULT : ST_PULSE_MUL;
            ST_PULSE_MUL:   state_next = ST_PULSE_CLAMP;
            ST_PULSE_CLAMP: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            offset_reg    <= '0;
            invert_reg    <= 1'b0;
            ppu_reg       <= PPU_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE: max_pulse_reg <= cfg_data[PULSE_W-1:0];
                CFG_MAX_ANGLE: max_angle_reg <= cfg_data[CUR_W-1:0];
                CFG_OFFSET:    offset_reg    <= cfg_data[OFS_W-1:0];
                CFG_INVERT:    invert_reg    <= cfg_data[0];
                CFG_PPU:       ppu_reg       <= cfg_data[PPU_W-1:0];
                default:       ;
            endcase
        end
    end

    // request capture and work registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func_t'(s_tuser);
            angle_in_reg <= s_tdata[ANGLE_W-1:0];
            speed_in_reg <= s_tdata[ANGLE_W+SPEED_W-1:ANGLE_W];
            ms_in_reg    <= s_tdata[ANGLE_W+SPEED_W+MS_W-1:ANGLE_W+SPEED_W];
        end
        if (state_reg == ST_DISPATCH)
            drive_reg <= angle_in_reg;
        if (state_reg == ST_STEP_CMP)
            drive_reg <= over ? angle_target_reg : next_w[ANGLE_W-1:0];
        if (state_reg == ST_STEP_MUL || state_reg == ST_STEP_DIV || state_reg == ST_PULSE_MUL)
            mul_reg <= mul_full[MUL_OUT_W-1:0];
    end

    // servo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_now_reg    <= '0;
            angle_target_reg <= '0;
            ramp_speed_reg   <= '0;
            ramp_active_reg  <= 1'b0;
            pulse_reg        <= '0;
            arrived_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_DISPATCH:
                begin
                    arrived_reg <= 1'b0;
                    if (func_reg == FUNC_MOVE)
                    begin
                        angle_target_reg <= target_new;
                        ramp_speed_reg   <= speed_in_reg;
                        ramp_active_reg  <= 1'b1;
                    end
                end
                ST_STEP_CMP:
                begin
                    if (!at_target)
                        arrived_reg <= over;
                end
                ST_PULSE_CLAMP:
                begin
                    pulse_reg     <= pulse_new;
                    angle_now_reg <= angle_new;
                    if (arrived_reg)
                    begin
                        ramp_speed_reg  <= '0;
                        ramp_active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_RESULT && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESULT && out_free)
            out_data_reg <= {1'b0, ramp_active_reg, arrived_reg, angle_now_reg, pulse_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DISPATCH)
        else $error("request not followed by dispatch");

    a_clamp_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PULSE_CLAMP |-> $past(state_reg) == ST_PULSE_MUL)
        else $error("pulse clamp without fresh product");

    a_arrived_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && arrived_reg) |-> func_reg == FUNC_TICK)
        else $error("arrival flagged on a non-tick request");

    a_arrived_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[CUR_W+PULSE_W]) |-> !out_data_reg[CUR_W+PULSE_W+1])
        else $error("arrived result still reports moving");

    a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result valid raised outside result state");
`endif

endmodule
